### hw/rtl/fcgi_pkg.sv
`timescale 1ns / 1ps

package fcgi_pkg;

  localparam int HDR_LEN    = 8;
  localparam int BODY_LEN   = 8;
  localparam int TYPE_MAX   = 10;
  localparam int GRP_MAX    = 3;
  localparam int GRP_CNT_W  = 2;
  localparam int CNT_W      = 3;

  localparam logic [7:0] TYPE_BEGIN     = 8'd1;
  localparam logic [7:0] TYPE_ABORT     = 8'd2;
  localparam logic [7:0] TYPE_END       = 8'd3;
  localparam logic [7:0] TYPE_STREAM_LO = 8'd4;
  localparam logic [7:0] TYPE_STREAM_HI = 8'd8;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_START   = 4'd1,
    EV_DATA    = 4'd2,
    EV_BEGIN   = 4'd3,
    EV_END_REQ = 4'd4,
    EV_ABORT   = 4'd5,
    EV_EOS     = 4'd6,
    EV_REC_END = 4'd7,
    EV_FAIL    = 4'd8
  } ev_t;

  // results caused by one byte; header/body fields gated by event at output
  typedef struct packed {
    logic [GRP_CNT_W-1:0] n;
    ev_t [GRP_MAX-1:0]    ev;
    logic [7:0]           record_type;
    logic [7:0]           version;
    logic [15:0]          request_id;
    logic [15:0]          content_length;
    logic [7:0]           padding_length;
    logic [7:0]           data_byte;
    logic [15:0]          role;
    logic [7:0]           flags;
    logic [31:0]          app_status;
    logic [7:0]           protocol_status;
  } grp_t;

endpackage

### hw/rtl/fastcgi_record_deframer_top.sv
`timescale 1ns / 1ps
// Each accepted byte's results are registered into a two-slot group buffer and offered from its head.
// Throughput: one byte per cycle while each byte yields at most one result and out_ready is high.
// A byte yielding k results (at most three) offers them in order, last on the final; results of
// up to two bytes are buffered, so in_ready drops only when both buffer slots are full.
// Reset: synchronous, clears parser state (awaiting header) and empties the buffer.

module fastcgi_record_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  event_res,
  output logic [7:0]  version,
  output logic [7:0]  record_type,
  output logic [15:0] request_id,
  output logic [15:0] content_length,
  output logic [7:0]  padding_length,
  output logic [7:0]  data_byte,
  output logic [15:0] role,
  output logic [7:0]  flags,
  output logic [31:0] app_status,
  output logic [7:0]  protocol_status,
  output logic        last
);

  fcgi_pkg::grp_t grp_in;
  fcgi_pkg::grp_t grp_q [2];
  fcgi_pkg::grp_t head;
  fcgi_pkg::ev_t  ev;
  logic           grp_push;
  logic           in_fire;
  logic           out_fire;
  logic           grp_pop;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic [fcgi_pkg::GRP_CNT_W-1:0] idx;
  logic           hdr_ev;

  assign in_ready = (cnt != 2'd2);
  assign in_fire  = in_valid && in_ready;

  fcgi_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .rx_byte  (rx_byte),
    .grp      (grp_in),
    .grp_push (grp_push)
  );

  assign head      = grp_q[rd_ptr];
  assign out_valid = (cnt != 2'd0);
  assign ev        = head.ev[idx];
  assign last      = (idx == head.n - 2'd1);
  assign out_fire  = out_valid && out_ready;
  assign grp_pop   = out_fire && last;
  assign hdr_ev    = (ev == fcgi_pkg::EV_START) || (ev == fcgi_pkg::EV_FAIL);

  assign event_res       = ev;
  assign record_type     = head.record_type;
  assign version         = hdr_ev ? head.version : 8'd0;
  assign request_id      = hdr_ev ? head.request_id : 16'd0;
  assign content_length  = hdr_ev ? head.content_length : 16'd0;
  assign padding_length  = hdr_ev ? head.padding_length : 8'd0;
  assign data_byte       = (ev == fcgi_pkg::EV_DATA) ? head.data_byte : 8'd0;
  assign role            = (ev == fcgi_pkg::EV_BEGIN) ? head.role : 16'd0;
  assign flags           = (ev == fcgi_pkg::EV_BEGIN) ? head.flags : 8'd0;
  assign app_status      = (ev == fcgi_pkg::EV_END_REQ) ? head.app_status : 32'd0;
  assign protocol_status = (ev == fcgi_pkg::EV_END_REQ) ? head.protocol_status : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= '0;
      idx    <= '0;
    end else begin
      if (grp_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (grp_pop) begin
        rd_ptr <= ~rd_ptr;
        idx    <= '0;
      end else if (out_fire) begin
        idx <= idx + 1'b1;
      end
      cnt <= cnt + {1'b0, grp_push} - {1'b0, grp_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (grp_push) begin
      grp_q[wr_ptr] <= grp_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("group buffer count out of range");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head.n != '0) && (idx < head.n))
    else $error("result index beyond buffered group");

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ev == fcgi_pkg::EV_FAIL) |-> last)
    else $error("failed result not last of its group");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) && !grp_pop |=> (cnt == 2'd2) && !in_ready)
    else $error("group buffer full but input accepted");

endmodule

### hw/rtl/fcgi_parse.sv
`timescale 1ns / 1ps

module fcgi_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        rx_byte,
  output fcgi_pkg::grp_t    grp,
  output logic              grp_push
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_BODY,
    PH_DISCARD,
    PH_PAD,
    PH_FAIL
  } phase_t;

  phase_t phase, phase_next;
  logic [fcgi_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [15:0] crem, crem_next;
  logic [7:0]  prem, prem_next;
  logic [7:0]  ctype, ctype_next;
  logic [7:0]  stage [fcgi_pkg::HDR_LEN-1];
  logic        stage_we;

  fcgi_pkg::ev_t ev_c [fcgi_pkg::GRP_MAX];
  logic [fcgi_pkg::GRP_CNT_W-1:0] n_c;
  logic [7:0]  body [5];
  logic        body_zero;
  logic [7:0]  t;
  logic [15:0] clen;
  logic [7:0]  plen;
  logic        last_cnt;

  assign t        = stage[1];
  assign clen     = {stage[4], stage[5]};
  assign plen     = stage[6];
  assign last_cnt = (cnt == fcgi_pkg::CNT_W'(fcgi_pkg::BODY_LEN - 1));

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      if (body_zero) begin
        body[j] = 8'd0;
      end else if (cnt > fcgi_pkg::CNT_W'(j)) begin
        body[j] = stage[j];
      end else if (cnt == fcgi_pkg::CNT_W'(j)) begin
        body[j] = rx_byte;
      end else begin
        body[j] = 8'd0;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    crem_next  = crem;
    prem_next  = prem;
    ctype_next = ctype;
    stage_we   = 1'b0;
    body_zero  = 1'b1;
    n_c        = '0;
    for (int i = 0; i < fcgi_pkg::GRP_MAX; i++) begin
      ev_c[i] = fcgi_pkg::EV_NONE;
    end
    case (phase)
      PH_FAIL: begin
      end
      PH_PAYLOAD: begin
        ev_c[n_c] = fcgi_pkg::EV_DATA;
        n_c = n_c + 2'd1;
        crem_next = crem - 16'd1;
        if (crem == 16'd1) begin
          if (prem == 8'd0) begin
            ev_c[n_c] = fcgi_pkg::EV_REC_END;
            n_c = n_c + 2'd1;
            phase_next = PH_HEADER;
          end else begin
            phase_next = PH_PAD;
          end
        end
      end
      PH_BODY: begin
        stage_we  = !last_cnt;
        cnt_next  = cnt + 1'b1;
        crem_next = crem - 16'd1;
        if (last_cnt || crem == 16'd1) begin
          body_zero = 1'b0;
          cnt_next  = '0;
          ev_c[n_c] = (ctype == fcgi_pkg::TYPE_BEGIN) ? fcgi_pkg::EV_BEGIN
                                                      : fcgi_pkg::EV_END_REQ;
          n_c = n_c + 2'd1;
          if (crem != 16'd1) begin
            phase_next = PH_DISCARD;
          end else if (prem == 8'd0) begin
            ev_c[n_c] = fcgi_pkg::EV_REC_END;
            n_c = n_c + 2'd1;
            phase_next = PH_HEADER;
          end else begin
            phase_next = PH_PAD;
          end
        end
      end
      PH_DISCARD: begin
        crem_next = crem - 16'd1;
        if (crem == 16'd1) begin
          if (prem == 8'd0) begin
            ev_c[n_c] = fcgi_pkg::EV_REC_END;
            n_c = n_c + 2'd1;
            phase_next = PH_HEADER;
          end else begin
            phase_next = PH_PAD;
          end
        end
      end
      PH_PAD: begin
        prem_next = prem - 8'd1;
        if (prem == 8'd1) begin
          ev_c[n_c] = fcgi_pkg::EV_REC_END;
          n_c = n_c + 2'd1;
          phase_next = PH_HEADER;
        end
      end
      default: begin
        phase_next = PH_HEADER;
        stage_we   = !last_cnt;
        cnt_next   = cnt + 1'b1;
        if (last_cnt) begin
          cnt_next   = '0;
          ctype_next = t;
          crem_next  = clen;
          prem_next  = plen;
          if (t == 8'd0 || t > 8'(fcgi_pkg::TYPE_MAX)) begin
            ev_c[n_c] = fcgi_pkg::EV_FAIL;
            n_c = n_c + 2'd1;
            phase_next = PH_FAIL;
          end else begin
            ev_c[n_c] = fcgi_pkg::EV_START;
            n_c = n_c + 2'd1;
            if (t == fcgi_pkg::TYPE_ABORT) begin
              ev_c[n_c] = fcgi_pkg::EV_ABORT;
              n_c = n_c + 2'd1;
            end else if (clen == 16'd0 && (t == fcgi_pkg::TYPE_BEGIN ||
                                            t == fcgi_pkg::TYPE_END)) begin
              ev_c[n_c] = (t == fcgi_pkg::TYPE_BEGIN) ? fcgi_pkg::EV_BEGIN
                                                      : fcgi_pkg::EV_END_REQ;
              n_c = n_c + 2'd1;
            end else if (clen == 16'd0 && t >= fcgi_pkg::TYPE_STREAM_LO &&
                         t <= fcgi_pkg::TYPE_STREAM_HI) begin
              ev_c[n_c] = fcgi_pkg::EV_EOS;
              n_c = n_c + 2'd1;
            end
            if (clen != 16'd0) begin
              if (t == fcgi_pkg::TYPE_ABORT) begin
                phase_next = PH_DISCARD;
              end else if (t == fcgi_pkg::TYPE_BEGIN || t == fcgi_pkg::TYPE_END) begin
                phase_next = PH_BODY;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end else if (plen == 8'd0) begin
              ev_c[n_c] = fcgi_pkg::EV_REC_END;
              n_c = n_c + 2'd1;
              phase_next = PH_HEADER;
            end else begin
              phase_next = PH_PAD;
            end
          end
        end
      end
    endcase
  end

  always_comb begin
    grp.n = n_c;
    for (int i = 0; i < fcgi_pkg::GRP_MAX; i++) begin
      grp.ev[i] = ev_c[i];
    end
    grp.record_type     = ctype_next;
    grp.version         = stage[0];
    grp.request_id      = {stage[2], stage[3]};
    grp.content_length  = clen;
    grp.padding_length  = plen;
    grp.data_byte       = rx_byte;
    grp.role            = {body[0], body[1]};
    grp.flags           = body[2];
    grp.app_status      = {body[0], body[1], body[2], body[3]};
    grp.protocol_status = body[4];
  end

  assign grp_push = in_fire && (n_c != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      cnt   <= '0;
      crem  <= '0;
      prem  <= '0;
      ctype <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      crem  <= crem_next;
      prem  <= prem_next;
      ctype <= ctype_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && stage_we) begin
      stage[cnt] <= rx_byte;
    end
  end

endmodule

### test/fastcgi_record_deframer_checker.sv
`timescale 1ns / 1ps

module fastcgi_record_deframer_checker
  import fcgi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  event_res,
  input  logic [7:0]  version,
  input  logic [7:0]  record_type,
  input  logic [15:0] request_id,
  input  logic [15:0] content_length,
  input  logic [7:0]  padding_length,
  input  logic [7:0]  data_byte,
  input  logic [15:0] role,
  input  logic [7:0]  flags,
  input  logic [31:0] app_status,
  input  logic [7:0]  protocol_status,
  input  logic        last,
  output int          error_count,
  output int          pending_results
);

  typedef enum logic [2:0] {
    P_HEADER,
    P_PAYLOAD,
    P_BODY,
    P_SKIP,
    P_PAD,
    P_DEAD
  } parse_phase_t;

  typedef struct {
    ev_t         ev;
    logic [7:0]  version;
    logic [7:0]  rtype;
    logic [15:0] rid;
    logic [15:0] clen;
    logic [7:0]  plen;
    logic [7:0]  data;
    logic [15:0] role;
    logic [7:0]  flags;
    logic [31:0] app;
    logic [7:0]  pst;
    logic        last;
  } record_event_t;

  parse_phase_t  phase;
  logic [3:0]    staged;
  logic [7:0]    stage [8];
  logic [7:0]    cur_type;
  logic [15:0]   content_left;
  logic [7:0]    pad_left;
  record_event_t expected_events [$];

  function automatic record_event_t make_event(ev_t ev);
    record_event_t e;
    e = '{ev: ev, rtype: cur_type, default: '0};
    return e;
  endfunction

  function automatic void close_content();
    if (pad_left == 8'd0) begin
      expected_events.push_back(make_event(EV_REC_END));
      phase = P_HEADER;
    end else begin
      phase = P_PAD;
    end
  endfunction

  // short bodies are zero-filled past the bytes actually staged
  function automatic void decode_body();
    record_event_t e;
    int i;
    for (i = 0; i < BODY_LEN; i++)
      if (i >= staged) stage[i] = 8'h00;
    staged = '0;
    if (cur_type == TYPE_BEGIN) begin
      e = make_event(EV_BEGIN);
      e.role = {stage[0], stage[1]};
      e.flags = stage[2];
    end else begin
      e = make_event(EV_END_REQ);
      e.app = {stage[0], stage[1], stage[2], stage[3]};
      e.pst = stage[4];
    end
    expected_events.push_back(e);
  endfunction

  function automatic void finish_header();
    record_event_t e;
    logic bad;
    cur_type = stage[1];
    content_left = {stage[4], stage[5]};
    pad_left = stage[6];
    staged = '0;
    bad = (cur_type == 8'd0) || (cur_type > TYPE_MAX);
    e = make_event(bad ? EV_FAIL : EV_START);
    e.version = stage[0];
    e.rid = {stage[2], stage[3]};
    e.clen = content_left;
    e.plen = pad_left;
    expected_events.push_back(e);
    if (bad) begin
      phase = P_DEAD;
    end else if (cur_type == TYPE_ABORT) begin
      expected_events.push_back(make_event(EV_ABORT));
      if (content_left != 16'd0) phase = P_SKIP;
      else close_content();
    end else if (cur_type == TYPE_BEGIN || cur_type == TYPE_END) begin
      if (content_left == 16'd0) begin
        decode_body();
        close_content();
      end else begin
        phase = P_BODY;
      end
    end else if (content_left == 16'd0) begin
      if (cur_type >= TYPE_STREAM_LO && cur_type <= TYPE_STREAM_HI)
        expected_events.push_back(make_event(EV_EOS));
      close_content();
    end else begin
      phase = P_PAYLOAD;
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    record_event_t e;
    int first;
    first = expected_events.size();
    case (phase)
      P_DEAD: begin
      end
      P_PAYLOAD: begin
        e = make_event(EV_DATA);
        e.data = b;
        expected_events.push_back(e);
        content_left = content_left - 16'd1;
        if (content_left == 16'd0) close_content();
      end
      P_BODY: begin
        stage[staged[2:0]] = b;
        staged = staged + 4'd1;
        content_left = content_left - 16'd1;
        if (staged >= BODY_LEN || content_left == 16'd0) begin
          decode_body();
          if (content_left != 16'd0) phase = P_SKIP;
          else close_content();
        end
      end
      P_SKIP: begin
        content_left = content_left - 16'd1;
        if (content_left == 16'd0) close_content();
      end
      P_PAD: begin
        pad_left = pad_left - 8'd1;
        if (pad_left == 8'd0) begin
          expected_events.push_back(make_event(EV_REC_END));
          phase = P_HEADER;
        end
      end
      default: begin
        stage[staged[2:0]] = b;
        staged = staged + 4'd1;
        if (staged >= HDR_LEN) finish_header();
      end
    endcase
    if (expected_events.size() > first) begin
      e = expected_events[expected_events.size() - 1];
      e.last = 1'b1;
      expected_events[expected_events.size() - 1] = e;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    record_event_t want;
    if (rst) begin
      phase = P_HEADER;
      staged = '0;
      cur_type = '0;
      content_left = '0;
      pad_left = '0;
      expected_events.delete();
      error_count = 0;
    end else begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("event_res: expected no transaction, got %0d", event_res);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", want.ev, event_res);
          check_field("version", want.version, version);
          check_field("record_type", want.rtype, record_type);
          check_field("request_id", want.rid, request_id);
          check_field("content_length", want.clen, content_length);
          check_field("padding_length", want.plen, padding_length);
          check_field("data_byte", want.data, data_byte);
          check_field("role", want.role, role);
          check_field("flags", want.flags, flags);
          check_field("app_status", want.app, app_status);
          check_field("protocol_status", want.pst, protocol_status);
          check_field("last", want.last, last);
        end
      end
    end
    pending_results <= expected_events.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import fcgi_pkg::*;

  localparam logic [7:0] TYPE_INVALID           = 8'd0;
  localparam logic [7:0] TYPE_GET_VALUES        = 8'd9;
  localparam logic [7:0] TYPE_GET_VALUES_RESULT = 8'd10;
  localparam int         STALL_LIMIT            = 2000;
  localparam int         HOLD_CYCLES            = 300;
  localparam int         PHASE_ITEMS            = 8;
  localparam int         TAIL_CYCLES            = 16;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  event_res;
  logic [7:0]  version;
  logic [7:0]  record_type;
  logic [15:0] request_id;
  logic [15:0] content_length;
  logic [7:0]  padding_length;
  logic [7:0]  data_byte;
  logic [15:0] role;
  logic [7:0]  flags;
  logic [31:0] app_status;
  logic [7:0]  protocol_status;
  logic        last;

  int error_count;
  int pending_results;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_len;
  int items_sent;

  fastcgi_record_deframer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .version(version), .record_type(record_type),
    .request_id(request_id), .content_length(content_length),
    .padding_length(padding_length), .data_byte(data_byte), .role(role),
    .flags(flags), .app_status(app_status), .protocol_status(protocol_status),
    .last(last)
  );

  fastcgi_record_deframer_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .version(version), .record_type(record_type),
    .request_id(request_id), .content_length(content_length),
    .padding_length(padding_length), .data_byte(data_byte), .role(role),
    .flags(flags), .app_status(app_status), .protocol_status(protocol_status),
    .last(last), .error_count(error_count), .pending_results(pending_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin : sink
    int n;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_record(input logic [7:0] ver, input logic [7:0] rtype,
                             input logic [15:0] rid, input logic [15:0] clen,
                             input logic [7:0] plen);
    int i;
    send_byte(ver);
    send_byte(rtype);
    send_byte(rid[15:8]);
    send_byte(rid[7:0]);
    send_byte(clen[15:8]);
    send_byte(clen[7:0]);
    send_byte(plen);
    send_byte(8'($urandom_range(255)));
    for (i = 0; i < clen; i++) send_byte(8'($urandom_range(255)));
    for (i = 0; i < plen; i++) send_byte(8'($urandom_range(255)));
    items_sent += HDR_LEN + int'(clen) + int'(plen);
  endtask

  task automatic rand_record();
    logic [7:0]  rtype;
    logic [15:0] clen;
    logic [7:0]  plen;
    rtype = 8'($urandom_range(TYPE_MAX, 1));
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: clen = 16'($urandom_range(10));
      6, 7:             clen = 16'($urandom_range(BODY_LEN + 1, BODY_LEN - 1));
      default:          clen = 16'($urandom_range(40));
    endcase
    plen = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(6, 1));
    send_record(8'($urandom_range(255)), rtype, 16'($urandom_range(16'hFFFF)), clen, plen);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct);
    int target;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) rand_record();
    drain();
  endtask

  initial begin : stimulus
    logic [7:0] t;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_len = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_record(8'h01, TYPE_BEGIN, 16'h0001, 16'd8, 8'd0);
    send_record(8'h01, TYPE_BEGIN, 16'h0002, 16'd0, 8'd0);
    send_record(8'h01, TYPE_BEGIN, 16'h0003, 16'd3, 8'd2);
    send_record(8'h01, TYPE_END, 16'h0004, 16'd8, 8'd1);
    send_record(8'h01, TYPE_END, 16'h0005, 16'd12, 8'd0);
    send_record(8'h01, TYPE_END, 16'h0006, 16'd0, 8'd3);
    send_record(8'h01, TYPE_ABORT, 16'h0007, 16'd0, 8'd0);
    send_record(8'h01, TYPE_ABORT, 16'h0008, 16'd5, 8'd2);
    for (t = TYPE_STREAM_LO; t <= TYPE_STREAM_HI; t++)
      send_record(8'h01, t, 16'h0010, 16'd0, {7'd0, t[0]});
    send_record(8'h01, TYPE_STREAM_LO + 8'd1, 16'h0011, 16'd4, 8'd0);
    send_record(8'h00, TYPE_GET_VALUES, 16'h0000, 16'd0, 8'd0);
    send_record(8'hFF, TYPE_GET_VALUES_RESULT, 16'hFFFF, 16'd3, 8'd1);
    // all-ones version and request id, body skip and longer padding
    send_record(8'hFF, TYPE_END, 16'hFFFF, 16'd10, 8'd7);
    drain();

    run_phase(53, 0);
    run_phase(0, 53);
    run_phase(26, 26);

    // receiver holds off while the sender keeps offering, block must back up
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_len = HOLD_CYCLES;
    send_record(8'h01, TYPE_STREAM_LO + 8'd1, 16'h0100, 16'd4, 8'd0);
    send_record(8'h01, TYPE_BEGIN, 16'h0101, 16'd0, 8'd0);
    send_record(8'h01, TYPE_STREAM_LO + 8'd2, 16'h0102, 16'd4, 8'd1);
    drain();

    run_phase(0, 0);

    // bad type last: the fail state only clears on reset
    case ($urandom_range(2))
      0:       t = TYPE_INVALID;
      1:       t = 8'(TYPE_MAX + 1);
      default: t = 8'($urandom_range(255, TYPE_MAX + 2));
    endcase
    src_idle_pct = 26;
    sink_stall_pct = 26;
    send_record(8'($urandom_range(255)), t, 16'($urandom_range(16'hFFFF)), 16'd2, 8'd1);
    repeat (4) send_byte(8'($urandom_range(255)));
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
